FILE: rtl/core/swsc_pkg.sv
`default_nettype none

package swsc_pkg;

    typedef logic [31:0] seq_t;
    typedef logic [27:0] q4_t;

    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_SUBMIT  = 2'd1;
    localparam logic [1:0] KIND_ACK     = 2'd2;
    localparam logic [1:0] KIND_CONNECT = 2'd3;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_TX_NEW  = 3'd1;
    localparam logic [2:0] EV_TIMEOUT = 3'd2;
    localparam logic [2:0] EV_FAST    = 3'd3;
    localparam logic [2:0] EV_REFUSED = 3'd4;
    localparam logic [2:0] EV_CLOSED  = 3'd5;

    localparam int         CFG_IDX_W   = 1;
    localparam logic [0:0] CFG_WINDOW  = 1'b0;
    localparam logic [0:0] CFG_MIN_DEV = 1'b1;

    localparam q4_t         Q_MAX         = 28'hFFF_FFFF;
    localparam q4_t         RTO_RESET     = 28'd160000;
    localparam logic [8:0]  WIN_RESET     = 9'd1;
    localparam logic [15:0] MIN_DEV_RESET = 16'd100;
    localparam logic [8:0]  CREDIT_MAX    = 9'd511;

endpackage

`default_nettype wire

FILE: rtl/core/sliding_window_sender_control.sv
// Sliding-window sender control: sequence, credit, timer and Jacobson RTO bookkeeping for a
// reliable sender. Every request gives exactly one result, after the transmit-time memory
// read and then the execute step into the output register. Ticks, submits, plain acks and
// duplicate acks finish in the first execute step; an ack is held off while another ack is
// in the execute slot, since its memory address follows the base that the first ack moves.
// An ack that advances the base and updates the RTO walks the shared RTO datapath through its
// first, estimate, difference, deviation, RTO and timer steps, holding the input; a connect
// takes the first and RTO steps. Transmit times live in a SLOTS-deep memory with one write and
// one registered read port; a read meeting a same-slot write in the same cycle is forwarded.
`default_nettype none

module sliding_window_sender_control
    import swsc_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           kind,
    input  wire logic [31:0]          ack_seq,
    input  wire logic [15:0]          recv_window,
    input  wire logic                 fin_flag,
    input  wire logic                 ack_flag,
    input  wire logic [15:0]          rtt_sample,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [2:0]           event_res,
    output logic      [31:0]          tx_seq,
    output logic      [7:0]           tx_slot,
    output logic                      all_acked,
    output logic      [31:0]          base_seq,
    output logic      [31:0]          next_seq_out,
    output logic      [8:0]           credits,
    output logic      [23:0]          rto_ticks,
    output logic      [15:0]          timeout_total,
    output logic      [15:0]          fast_retx_total,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data
);

    localparam int SW = $clog2(SLOTS);
    localparam int XW = (SW > 8) ? SW : 8;

    typedef logic [SW-1:0] slot_t;
    typedef logic [SW:0]   slot_sum_t;

    localparam slot_t     SLOT_LAST = SW'(SLOTS - 1);
    localparam slot_sum_t SLOT_CNT  = (SW + 1)'(SLOTS);

    typedef enum logic [2:0] {
        STP_FIRST,
        STP_EST,
        STP_DIFF,
        STP_DEV,
        STP_RTO,
        STP_TMR
    } step_t;

    // execute slot
    logic        ex_valid_reg, ex_valid_next;
    step_t       step_reg, step_next;
    logic [1:0]  ex_kind_reg, ex_kind_next;
    seq_t        ex_ack_reg, ex_ack_next;
    logic [15:0] ex_rwin_reg, ex_rwin_next;
    logic        ex_fin_reg, ex_fin_next;
    logic        ex_ackf_reg, ex_ackf_next;
    logic [15:0] ex_rtts_reg, ex_rtts_next;
    logic        fwd_hit_reg, fwd_hit_next;
    seq_t        fwd_data_reg, fwd_data_next;

    // sender state
    seq_t        next_seq_reg, next_seq_next;
    seq_t        base_reg, base_next;
    seq_t        rel_lim_reg, rel_lim_next;
    logic [2:0]  dup_reg, dup_next;
    logic [7:0]  br_reg, br_next;
    q4_t         est_reg, est_next;
    q4_t         dev_reg, dev_next;
    q4_t         rto_reg, rto_next;
    q4_t         samp_reg, samp_next;
    q4_t         diff_reg, diff_next;
    seq_t        now_reg, now_next;
    seq_t        tmr_reg, tmr_next;
    logic [15:0] to_cnt_reg, to_cnt_next;
    logic [15:0] fr_cnt_reg, fr_cnt_next;
    logic        closed_reg, closed_next;
    slot_t       next_slot_reg, next_slot_next;
    slot_t       base_slot_reg, base_slot_next;
    logic [8:0]  win_reg, win_next;
    logic [15:0] mindev_reg, mindev_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_ev_reg, out_ev_next;
    seq_t        out_txs_reg, out_txs_next;
    logic [7:0]  out_slot_reg, out_slot_next;
    logic        out_allk_reg, out_allk_next;
    seq_t        out_base_reg, out_base_next;
    seq_t        out_next_reg, out_next_next;
    seq_t        out_rl_reg, out_rl_next;
    logic [23:0] out_rto_reg, out_rto_next;
    logic [15:0] out_to_reg, out_to_next;
    logic [15:0] out_fr_reg, out_fr_next;

    // memory
    logic        ram_we;
    slot_t       ram_waddr;
    seq_t        ram_wdata;
    slot_t       ram_raddr;
    seq_t        ram_rdata;

    logic        in_accept;
    logic        out_free;
    logic        go;
    logic        finish;
    logic        ex_free;
    logic        ack_hazard;

    seq_t        rd_da;
    slot_sum_t   rd_sum;

    seq_t        now_inc;
    seq_t        tmo_diff;
    seq_t        restart_now;
    seq_t        restart_tick;
    seq_t        da;
    seq_t        dn;
    seq_t        cr;
    logic        cr_zero;
    logic [15:0] eff_lo;
    logic [16:0] eff;
    seq_t        lim_base;
    seq_t        cand;
    logic        cand_up;
    seq_t        tx_t;
    seq_t        el;
    q4_t         samp_new;
    slot_sum_t   bslot_sum;
    logic [31:0] est_sum;
    logic [29:0] dev_sum;
    logic [19:0] dev_floor;
    q4_t         dev_eff;
    logic [30:0] rto_sum;
    logic [2:0]  ev;
    seq_t        txs;
    slot_t       tslot;
    logic [XW-1:0] tslot_ext;
    logic        allk;
    seq_t        cr_o;

    swsc_ram #(
        .WIDTH (32),
        .DEPTH (SLOTS)
    ) u_tx_time (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (in_accept),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign cfg_ready = 1'b1;

    // slot of ack-1, relative to the base slot
    assign rd_da     = ack_seq - base_reg;
    assign rd_sum    = (SW + 1)'(base_slot_reg) + rd_da[SW:0] - (SW + 1)'(1);
    assign ram_raddr = (rd_sum >= SLOT_CNT) ? SW'(rd_sum - SLOT_CNT) : rd_sum[SW-1:0];

    assign out_free   = !out_valid_reg || !out_stall;
    assign go         = (step_reg == STP_FIRST || step_reg == STP_RTO || step_reg == STP_TMR)
                        ? out_free : 1'b1;
    assign ex_free    = !ex_valid_reg || (finish && go);
    assign ack_hazard = (kind == KIND_ACK) && ex_valid_reg && (ex_kind_reg == KIND_ACK);
    assign in_stall   = !ex_free || ack_hazard;
    assign in_accept  = in_valid && !in_stall;

    assign now_inc      = now_reg + 32'd1;
    assign tmo_diff     = now_inc - tmr_reg;
    assign restart_now  = now_reg + 32'(rto_reg[27:4]);
    assign restart_tick = now_reg + 32'(rto_reg[27:4]) + 32'd1;
    assign da           = ex_ack_reg - base_reg;
    assign dn           = next_seq_reg - base_reg;
    assign cr           = rel_lim_reg - next_seq_reg;
    assign cr_zero      = (cr == 32'd0) || cr[31];

    assign eff_lo   = (16'(win_reg) < ex_rwin_reg) ? 16'(win_reg) : ex_rwin_reg;
    assign eff      = (17'(eff_lo) > 17'(SLOTS)) ? 17'(SLOTS) : 17'(eff_lo);
    assign lim_base = (ex_kind_reg == KIND_ACK) ? ex_ack_reg : base_reg;
    assign cand     = lim_base + 32'(eff);
    assign cand_up  = ((cand - rel_lim_reg) < 32'h8000_0000);

    assign tx_t      = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign el        = now_reg - tx_t;
    assign samp_new  = (el[31:24] != 8'd0) ? Q_MAX : {el[23:0], 4'd0};
    assign bslot_sum = (SW + 1)'(base_slot_reg) + da[SW:0];

    assign est_sum   = (32'(est_reg) << 3) - 32'(est_reg) + 32'(samp_reg);
    assign dev_sum   = (30'(dev_reg) << 1) + 30'(dev_reg) + 30'(diff_reg);
    assign dev_floor = {mindev_reg, 4'd0};
    assign dev_eff   = (dev_reg > 28'(dev_floor)) ? dev_reg : 28'(dev_floor);
    assign rto_sum   = 31'(est_reg) + {1'b0, dev_eff, 2'd0};

    always_comb
    begin
        ex_valid_next  = ex_valid_reg;
        step_next      = step_reg;
        ex_kind_next   = ex_kind_reg;
        ex_ack_next    = ex_ack_reg;
        ex_rwin_next   = ex_rwin_reg;
        ex_fin_next    = ex_fin_reg;
        ex_ackf_next   = ex_ackf_reg;
        ex_rtts_next   = ex_rtts_reg;
        fwd_hit_next   = fwd_hit_reg;
        fwd_data_next  = fwd_data_reg;
        next_seq_next  = next_seq_reg;
        base_next      = base_reg;
        rel_lim_next   = rel_lim_reg;
        dup_next       = dup_reg;
        br_next        = br_reg;
        est_next       = est_reg;
        dev_next       = dev_reg;
        rto_next       = rto_reg;
        samp_next      = samp_reg;
        diff_next      = diff_reg;
        now_next       = now_reg;
        tmr_next       = tmr_reg;
        to_cnt_next    = to_cnt_reg;
        fr_cnt_next    = fr_cnt_reg;
        closed_next    = closed_reg;
        next_slot_next = next_slot_reg;
        base_slot_next = base_slot_reg;
        win_next       = win_reg;
        mindev_next    = mindev_reg;
        out_valid_next = out_valid_reg;
        out_ev_next    = out_ev_reg;
        out_txs_next   = out_txs_reg;
        out_slot_next  = out_slot_reg;
        out_allk_next  = out_allk_reg;
        out_base_next  = out_base_reg;
        out_next_next  = out_next_reg;
        out_rl_next    = out_rl_reg;
        out_rto_next   = out_rto_reg;
        out_to_next    = out_to_reg;
        out_fr_next    = out_fr_reg;
        ram_we         = 1'b0;
        ram_waddr      = next_slot_reg;
        ram_wdata      = now_reg;
        finish         = 1'b0;
        ev             = EV_NONE;
        txs            = 32'd0;
        tslot          = '0;
        allk           = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_WINDOW:  win_next    = cfg_data[8:0];
                CFG_MIN_DEV: mindev_next = cfg_data;
                default:     ;
            endcase
        end

        if (ex_valid_reg && go)
        begin
            case (step_reg)
                STP_FIRST:
                begin
                    case (ex_kind_reg)
                        KIND_TICK:
                        begin
                            finish   = 1'b1;
                            now_next = now_inc;
                            if (!closed_reg && (base_reg != next_seq_reg) && !tmo_diff[31])
                            begin
                                ev       = EV_TIMEOUT;
                                txs      = base_reg;
                                tslot    = base_slot_reg;
                                tmr_next = restart_tick;
                                if (br_reg != 8'hFF)
                                begin
                                    br_next = br_reg + 8'd1;
                                end
                                if (to_cnt_reg != 16'hFFFF)
                                begin
                                    to_cnt_next = to_cnt_reg + 16'd1;
                                end
                            end
                        end
                        KIND_SUBMIT:
                        begin
                            finish = 1'b1;
                            if (closed_reg || cr_zero)
                            begin
                                ev = EV_REFUSED;
                            end
                            else
                            begin
                                ev            = EV_TX_NEW;
                                txs           = next_seq_reg;
                                tslot         = next_slot_reg;
                                ram_we        = 1'b1;
                                next_seq_next = next_seq_reg + 32'd1;
                                next_slot_next = (next_slot_reg == SLOT_LAST)
                                                 ? '0 : next_slot_reg + SW'(1);
                                if (next_seq_reg == base_reg)
                                begin
                                    tmr_next = restart_now;
                                end
                            end
                        end
                        KIND_ACK:
                        begin
                            finish = 1'b1;
                            if (!closed_reg)
                            begin
                                if (ex_fin_reg && ex_ackf_reg)
                                begin
                                    closed_next = 1'b1;
                                    ev          = EV_CLOSED;
                                end
                                else
                                begin
                                    allk = (ex_ack_reg == next_seq_reg);
                                    if ((da != 32'd0) && (da <= dn))
                                    begin
                                        dup_next       = 3'd0;
                                        br_next        = 8'd0;
                                        base_next      = ex_ack_reg;
                                        base_slot_next = (bslot_sum >= SLOT_CNT)
                                                         ? SW'(bslot_sum - SLOT_CNT)
                                                         : bslot_sum[SW-1:0];
                                        if (cand_up)
                                        begin
                                            rel_lim_next = cand;
                                        end
                                        if (br_reg == 8'd0)
                                        begin
                                            finish    = 1'b0;
                                            samp_next = samp_new;
                                            step_next = STP_EST;
                                        end
                                        else
                                        begin
                                            tmr_next = restart_now;
                                        end
                                    end
                                    else if ((da == 32'd0) && (dn != 32'd0))
                                    begin
                                        if (dup_reg != 3'd7)
                                        begin
                                            dup_next = dup_reg + 3'd1;
                                        end
                                        if (dup_reg == 3'd2)
                                        begin
                                            ev       = EV_FAST;
                                            txs      = base_reg;
                                            tslot    = base_slot_reg;
                                            tmr_next = restart_now;
                                            if (br_reg != 8'hFF)
                                            begin
                                                br_next = br_reg + 8'd1;
                                            end
                                            if (fr_cnt_reg != 16'hFFFF)
                                            begin
                                                fr_cnt_next = fr_cnt_reg + 16'd1;
                                            end
                                        end
                                    end
                                end
                            end
                        end
                        KIND_CONNECT:
                        begin
                            closed_next = 1'b0;
                            dup_next    = 3'd0;
                            br_next     = 8'd0;
                            est_next    = 28'({ex_rtts_reg, 4'd0});
                            dev_next    = '0;
                            if (cand_up)
                            begin
                                rel_lim_next = cand;
                            end
                            step_next = STP_RTO;
                        end
                        default: ;
                    endcase
                end
                STP_EST:
                begin
                    est_next  = est_sum[30:3];
                    step_next = STP_DIFF;
                end
                STP_DIFF:
                begin
                    diff_next = (samp_reg > est_reg) ? samp_reg - est_reg : est_reg - samp_reg;
                    step_next = STP_DEV;
                end
                STP_DEV:
                begin
                    dev_next  = dev_sum[29:2];
                    step_next = STP_RTO;
                end
                STP_RTO:
                begin
                    rto_next = (rto_sum > 31'(Q_MAX)) ? Q_MAX : rto_sum[27:0];
                    if (ex_kind_reg == KIND_ACK)
                    begin
                        step_next = STP_TMR;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                STP_TMR:
                begin
                    tmr_next = restart_now;
                    allk     = (ex_ack_reg == next_seq_reg);
                    finish   = 1'b1;
                end
                default: ;
            endcase
        end

        tslot_ext = XW'(tslot);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (ex_valid_reg && go && finish)
        begin
            out_valid_next = 1'b1;
            out_ev_next    = ev;
            out_txs_next   = txs;
            out_slot_next  = tslot_ext[7:0];
            out_allk_next  = allk;
            out_base_next  = base_next;
            out_next_next  = next_seq_next;
            out_rl_next    = rel_lim_next;
            out_rto_next   = rto_next[27:4];
            out_to_next    = to_cnt_next;
            out_fr_next    = fr_cnt_next;
            ex_valid_next  = 1'b0;
        end

        fwd_hit_next = 1'b0;
        if (in_accept)
        begin
            ex_valid_next = 1'b1;
            step_next     = STP_FIRST;
            ex_kind_next  = kind;
            ex_ack_next   = ack_seq;
            ex_rwin_next  = recv_window;
            ex_fin_next   = fin_flag;
            ex_ackf_next  = ack_flag;
            ex_rtts_next  = rtt_sample;
            fwd_hit_next  = ram_we && (ram_waddr == ram_raddr);
            fwd_data_next = ram_wdata;
        end
        else if (ex_valid_reg)
        begin
            fwd_hit_next = fwd_hit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg  <= 1'b0;
            step_reg      <= STP_FIRST;
            fwd_hit_reg   <= 1'b0;
            next_seq_reg  <= '0;
            base_reg      <= '0;
            rel_lim_reg   <= '0;
            dup_reg       <= '0;
            br_reg        <= '0;
            est_reg       <= '0;
            dev_reg       <= '0;
            rto_reg       <= RTO_RESET;
            now_reg       <= '0;
            tmr_reg       <= '0;
            to_cnt_reg    <= '0;
            fr_cnt_reg    <= '0;
            closed_reg    <= 1'b0;
            next_slot_reg <= '0;
            base_slot_reg <= '0;
            win_reg       <= WIN_RESET;
            mindev_reg    <= MIN_DEV_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ex_valid_reg  <= ex_valid_next;
            step_reg      <= step_next;
            fwd_hit_reg   <= fwd_hit_next;
            next_seq_reg  <= next_seq_next;
            base_reg      <= base_next;
            rel_lim_reg   <= rel_lim_next;
            dup_reg       <= dup_next;
            br_reg        <= br_next;
            est_reg       <= est_next;
            dev_reg       <= dev_next;
            rto_reg       <= rto_next;
            now_reg       <= now_next;
            tmr_reg       <= tmr_next;
            to_cnt_reg    <= to_cnt_next;
            fr_cnt_reg    <= fr_cnt_next;
            closed_reg    <= closed_next;
            next_slot_reg <= next_slot_next;
            base_slot_reg <= base_slot_next;
            win_reg       <= win_next;
            mindev_reg    <= mindev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ex_kind_reg  <= ex_kind_next;
        ex_ack_reg   <= ex_ack_next;
        ex_rwin_reg  <= ex_rwin_next;
        ex_fin_reg   <= ex_fin_next;
        ex_ackf_reg  <= ex_ackf_next;
        ex_rtts_reg  <= ex_rtts_next;
        fwd_data_reg <= fwd_data_next;
        samp_reg     <= samp_next;
        diff_reg     <= diff_next;
        out_ev_reg   <= out_ev_next;
        out_txs_reg  <= out_txs_next;
        out_slot_reg <= out_slot_next;
        out_allk_reg <= out_allk_next;
        out_base_reg <= out_base_next;
        out_next_reg <= out_next_next;
        out_rl_reg   <= out_rl_next;
        out_rto_reg  <= out_rto_next;
        out_to_reg   <= out_to_next;
        out_fr_reg   <= out_fr_next;
    end

    // credits from the held limit and next sequence
    assign cr_o = out_rl_reg - out_next_reg;

    assign out_valid       = out_valid_reg;
    assign event_res       = out_ev_reg;
    assign tx_seq          = out_txs_reg;
    assign tx_slot         = out_slot_reg;
    assign all_acked       = out_allk_reg;
    assign base_seq        = out_base_reg;
    assign next_seq_out    = out_next_reg;
    assign credits         = cr_o[31] ? 9'd0
                             : ((cr_o[30:9] != 22'd0) ? CREDIT_MAX : cr_o[8:0]);
    assign rto_ticks       = out_rto_reg;
    assign timeout_total   = out_to_reg;
    assign fast_retx_total = out_fr_reg;

endmodule

`default_nettype wire

FILE: rtl/core/swsc_ram.sv
`default_nettype none

module swsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/swsc_checker.sv
`default_nettype none

module swsc_checker
    import swsc_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [2:0]  event_res,
    input wire logic [31:0] tx_seq,
    input wire logic [7:0]  tx_slot,
    input wire logic        all_acked,
    input wire logic [31:0] base_seq,
    input wire logic [31:0] next_seq_out
);

    // no sequence on events that send nothing
    a_quiet_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_NONE || event_res == EV_REFUSED
                      || event_res == EV_CLOSED)
        |-> tx_seq == 32'd0 && tx_slot == 8'd0)
        else $error("tx_seq or tx_slot set on a non-transmit result");

    a_tx_next: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_TX_NEW |-> next_seq_out == tx_seq + 32'd1)
        else $error("new transmit did not advance next sequence");

    a_all_acked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && all_acked |-> base_seq == next_seq_out)
        else $error("all_acked with packets still outstanding");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_res) && $stable(tx_seq))
        else $error("stalled result changed");

endmodule

bind sliding_window_sender_control swsc_checker u_swsc_checker (.*);

`default_nettype wire
